/* hw/rtl/owbm_pkg.sv */
// Shared types and command codes for the one-wire bus master core.
`timescale 1ns / 1ps

package owbm_pkg;

   // Request command codes
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_RESET_LOW    = 3'd0,
      REG_RESET_SAMPLE = 3'd1,
      REG_RESET_PERIOD = 3'd2,
      REG_WRITE_ONE    = 3'd3,
      REG_WRITE_ZERO   = 3'd4,
      REG_READ_LOW     = 3'd5,
      REG_READ_SAMPLE  = 3'd6,
      REG_SLOT_PERIOD  = 3'd7
   } reg_index_type;

   localparam int unsigned TICK_W = 16;

   // Timing registers as seen by the engine
   typedef struct packed {
      logic [TICK_W-1:0] reset_low_ticks;
      logic [TICK_W-1:0] reset_sample_ticks;
      logic [TICK_W-1:0] reset_period_ticks;
      logic [TICK_W-1:0] write_one_low_ticks;
      logic [TICK_W-1:0] write_zero_low_ticks;
      logic [TICK_W-1:0] read_low_ticks;
      logic [TICK_W-1:0] read_sample_ticks;
      logic [TICK_W-1:0] slot_period_ticks;
   } cfg_type;

   // One result item, packed lowest field last so rsp_tdata maps directly
   typedef struct packed {
      logic [7:0] read_data;
      logic       presence_found;
      logic       done_res;
      logic       rejected;
      logic       busy_res;
      logic       drive_low;
   } rsp_type;

   localparam int unsigned RSP_W = $bits(rsp_type);

endpackage

/* hw/rtl/owbm_cfg.sv */
// Timing register file written through the csr port.
`timescale 1ns / 1ps

module owbm_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [2:0]                          csr_index,
   input  logic [owbm_pkg::TICK_W-1:0]         csr_wdata,
   output owbm_pkg::cfg_type                   cfg
);

   owbm_pkg::cfg_type cfg_ff;

   // Registers load their defaults at reset and take writes by index
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks      <= 16'd4000;
         cfg_ff.reset_sample_ticks   <= 16'd4520;
         cfg_ff.reset_period_ticks   <= 16'd8200;
         cfg_ff.write_one_low_ticks  <= 16'd120;
         cfg_ff.write_zero_low_ticks <= 16'd512;
         cfg_ff.read_low_ticks       <= 16'd8;
         cfg_ff.read_sample_ticks    <= 16'd64;
         cfg_ff.slot_period_ticks    <= 16'd592;
      end else if (csr_we) begin
         case (owbm_pkg::reg_index_type'(csr_index))
            owbm_pkg::REG_RESET_LOW:    cfg_ff.reset_low_ticks      <= csr_wdata;
            owbm_pkg::REG_RESET_SAMPLE: cfg_ff.reset_sample_ticks   <= csr_wdata;
            owbm_pkg::REG_RESET_PERIOD: cfg_ff.reset_period_ticks   <= csr_wdata;
            owbm_pkg::REG_WRITE_ONE:    cfg_ff.write_one_low_ticks  <= csr_wdata;
            owbm_pkg::REG_WRITE_ZERO:   cfg_ff.write_zero_low_ticks <= csr_wdata;
            owbm_pkg::REG_READ_LOW:     cfg_ff.read_low_ticks       <= csr_wdata;
            owbm_pkg::REG_READ_SAMPLE:  cfg_ff.read_sample_ticks    <= csr_wdata;
            owbm_pkg::REG_SLOT_PERIOD:  cfg_ff.slot_period_ticks    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/owbm_engine.sv */
// Transaction state and per-tick slot logic of the one-wire master.
`timescale 1ns / 1ps

module owbm_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [1:0]             op,
   input  logic [7:0]             data_byte,
   input  logic                   line_level,
   input  owbm_pkg::cfg_type      cfg,
   output owbm_pkg::rsp_type      rsp
);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_RESET = 2'd1,
      PH_WRITE = 2'd2,
      PH_READ  = 2'd3
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [owbm_pkg::TICK_W-1:0]      tick_ff, tick_in;
   logic [2:0]                       bit_ff, bit_in;
   logic [7:0]                       shift_ff, shift_in;
   logic                             presence_ff, presence_in;
   logic [7:0]                       last_read_ff, last_read_in;

   phase_type                        ph;
   logic [owbm_pkg::TICK_W-1:0]      low;
   logic [owbm_pkg::TICK_W-1:0]      period;
   logic [owbm_pkg::TICK_W:0]        next_t;
   logic                             drive, rej, done;

   // One tick of the transaction
   always_comb begin
      ph           = phase_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      presence_in  = presence_ff;
      last_read_in = last_read_ff;
      rej          = 1'b0;
      done         = 1'b0;
      drive        = 1'b0;
      low          = '0;
      period       = '0;

      // Start or reject a command
      if (owbm_pkg::op_type'(op) != owbm_pkg::OP_TICK) begin
         if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else begin
            tick_in = '0;
            bit_in  = '0;
            case (owbm_pkg::op_type'(op))
               owbm_pkg::OP_RESET: begin
                  ph          = PH_RESET;
                  presence_in = 1'b0;
                  shift_in    = '0;
               end
               owbm_pkg::OP_WRITE: begin
                  ph       = PH_WRITE;
                  shift_in = data_byte;
               end
               default: begin
                  ph       = PH_READ;
                  shift_in = '0;
               end
            endcase
         end
      end

      // Slot timing for the running transaction
      case (ph)
         PH_RESET: begin
            low    = cfg.reset_low_ticks;
            period = cfg.reset_period_ticks;
            if (tick_in == cfg.reset_sample_ticks) presence_in = ~line_level;
         end
         PH_WRITE: begin
            low    = shift_in[bit_in] ? cfg.write_one_low_ticks
                                      : cfg.write_zero_low_ticks;
            period = cfg.slot_period_ticks;
         end
         PH_READ: begin
            low    = cfg.read_low_ticks;
            period = cfg.slot_period_ticks;
            if (tick_in == cfg.read_sample_ticks && line_level) shift_in[bit_in] = 1'b1;
         end
         default: ;
      endcase

      next_t   = {1'b0, tick_in} + (owbm_pkg::TICK_W+1)'(1);
      phase_in = ph;
      if (ph != PH_IDLE) begin
         drive = (tick_in < low);
         if (next_t >= {1'b0, period}) begin
            tick_in = '0;
            if (ph == PH_RESET || bit_in == 3'd7) begin
               if (ph == PH_READ) last_read_in = shift_in;
               phase_in = PH_IDLE;
               bit_in   = '0;
               done     = 1'b1;
            end else begin
               bit_in = bit_in + 3'd1;
            end
         end else begin
            tick_in = next_t[owbm_pkg::TICK_W-1:0];
         end
      end

      rsp.drive_low      = drive;
      rsp.busy_res       = (phase_in != PH_IDLE);
      rsp.rejected       = rej;
      rsp.done_res       = done;
      rsp.presence_found = presence_in;
      rsp.read_data      = last_read_in;
   end

   // State advances once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         presence_ff  <= 1'b0;
         last_read_ff <= '0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         presence_ff  <= presence_in;
         last_read_ff <= last_read_in;
      end
   end

endmodule

/* hw/rtl/one_wire_bus_master_core.sv */
// Top level of the one-wire bus master: request register, engine, result register.
//
// Usage: each request on req_* is one tick of the 1/8 us time base. req_tuser
// carries the command (tick, bus reset, write byte, read byte), req_tdata the
// byte to send and the sampled bus level. Every request yields exactly one
// result on rsp_*: drive_low for the bus, busy, rejected, done, presence
// status and the last byte read.
// Path: a request is captured in the request register, passes the engine, and its
// result is captured in the result register, from which it shows on rsp_*.
// Throughput: one request per cycle while rsp_tready does not hold the result register;
// the engine state updates once per accepted request, so back-to-back ticks run at full rate.
// Stalls: when rsp_tready is low the result register holds and the request
// register fills; req_tready drops only once both are occupied.
// Reset: synchronous; clears both registers and the transaction state, and loads
// the default timing registers. Timing registers are written through csr_* only
// while no request is in flight, a rule on the user that the block does not enforce;
// a write applies from the next request on, also in the middle of a transaction.
`timescale 1ns / 1ps

module one_wire_bus_master_core (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // [7:0] data_byte, [8] line_level
   input  logic [1:0]                      req_tuser,  // [1:0] operation
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // [0] drive_low, [1] busy_res,
                                                       // [2] rejected, [3] done_res,
                                                       // [4] presence_found, [12:5] read_data
   // configuration
   input  logic                            csr_we,
   input  logic [2:0]                      csr_index,
   input  logic [owbm_pkg::TICK_W-1:0]     csr_wdata
);

   owbm_pkg::cfg_type cfg;
   owbm_pkg::rsp_type step_rsp;

   logic       in_valid_ff;
   logic [1:0] in_op_ff;
   logic [7:0] in_data_ff;
   logic       in_line_ff;

   logic              out_valid_ff;
   owbm_pkg::rsp_type out_data_ff;

   logic advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   owbm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owbm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .op         (in_op_ff),
      .data_byte  (in_data_ff),
      .line_level (in_line_ff),
      .cfg        (cfg),
      .rsp        (step_rsp)
   );

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_data_ff <= req_tdata[7:0];
         in_line_ff <= req_tdata[8];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(16 - owbm_pkg::RSP_W){1'b0}}, out_data_ff};

endmodule

/* verif/tb.sv */
// Self-checking testbench for the one-wire bus master core, with a per-tick bus predictor.
`timescale 1ns / 1ps

module tb;

   localparam int STALL_LIMIT = 5000;  // cycles with no transfer before the watchdog trips
   localparam int LONG_HOLD   = 300;   // one long result-side hold-off
   localparam int MAX_REPORTS = 40;    // cap on printed mismatch lines

   // Bus line behavior while a transaction runs
   localparam int LINE_LOW    = 0;
   localparam int LINE_HIGH   = 1;
   localparam int LINE_RANDOM = 2;

   // Predicts the result of every tick from its own copy of the timing and bus state
   class one_wire_predictor;
      logic [15:0]       timing [8];
      owbm_pkg::op_type  phase;   // OP_TICK doubles as idle
      logic [15:0]       tick_count;
      logic [2:0]        bit_index;
      logic [7:0]        shift_byte;
      logic              presence_flag;
      logic [7:0]        last_read;
      owbm_pkg::rsp_type expected_ticks [$];
      int                errors;

      function new();
         timing[owbm_pkg::REG_RESET_LOW]    = 16'd4000;
         timing[owbm_pkg::REG_RESET_SAMPLE] = 16'd4520;
         timing[owbm_pkg::REG_RESET_PERIOD] = 16'd8200;
         timing[owbm_pkg::REG_WRITE_ONE]    = 16'd120;
         timing[owbm_pkg::REG_WRITE_ZERO]   = 16'd512;
         timing[owbm_pkg::REG_READ_LOW]     = 16'd8;
         timing[owbm_pkg::REG_READ_SAMPLE]  = 16'd64;
         timing[owbm_pkg::REG_SLOT_PERIOD]  = 16'd592;
         phase         = owbm_pkg::OP_TICK;
         tick_count    = '0;
         bit_index     = '0;
         shift_byte    = '0;
         presence_flag = 1'b0;
         last_read     = '0;
         errors        = 0;
      endfunction

      function void set_timing(owbm_pkg::reg_index_type idx, logic [15:0] value);
         timing[idx] = value;
      endfunction

      // Advance one tick for an accepted request and queue the expected result
      function void advance_tick(owbm_pkg::op_type op, logic [7:0] data_byte,
                                 logic line_level);
         owbm_pkg::rsp_type r;
         logic [16:0]       next_count;
         logic [15:0]       low_ticks;
         logic [15:0]       period_ticks;
         r = '0;
         if (op != owbm_pkg::OP_TICK) begin
            if (phase != owbm_pkg::OP_TICK) begin
               r.rejected = 1'b1;
            end else begin
               phase      = op;
               tick_count = '0;
               bit_index  = '0;
               case (op)
                  owbm_pkg::OP_RESET: begin
                     presence_flag = 1'b0;
                     shift_byte    = '0;
                  end
                  owbm_pkg::OP_WRITE: shift_byte = data_byte;
                  default:            shift_byte = '0;
               endcase
            end
         end

         if (phase != owbm_pkg::OP_TICK) begin
            next_count = {1'b0, tick_count} + 17'd1;
            case (phase)
               owbm_pkg::OP_RESET: begin
                  low_ticks    = timing[owbm_pkg::REG_RESET_LOW];
                  period_ticks = timing[owbm_pkg::REG_RESET_PERIOD];
                  if (tick_count == timing[owbm_pkg::REG_RESET_SAMPLE])
                     presence_flag = ~line_level;
               end
               owbm_pkg::OP_WRITE: begin
                  low_ticks    = shift_byte[bit_index] ? timing[owbm_pkg::REG_WRITE_ONE]
                                                       : timing[owbm_pkg::REG_WRITE_ZERO];
                  period_ticks = timing[owbm_pkg::REG_SLOT_PERIOD];
               end
               default: begin
                  low_ticks    = timing[owbm_pkg::REG_READ_LOW];
                  period_ticks = timing[owbm_pkg::REG_SLOT_PERIOD];
                  if (tick_count == timing[owbm_pkg::REG_READ_SAMPLE] && line_level)
                     shift_byte[bit_index] = 1'b1;
               end
            endcase
            r.drive_low = (tick_count < low_ticks);

            // End of slot or reset period
            if (next_count >= {1'b0, period_ticks}) begin
               tick_count = '0;
               if (phase == owbm_pkg::OP_RESET || bit_index == 3'd7) begin
                  if (phase == owbm_pkg::OP_READ)
                     last_read = shift_byte;
                  phase     = owbm_pkg::OP_TICK;
                  bit_index = '0;
                  r.done_res = 1'b1;
               end else begin
                  bit_index = bit_index + 3'd1;
               end
            end else begin
               tick_count = next_count[15:0];
            end
         end

         r.busy_res       = (phase != owbm_pkg::OP_TICK);
         r.presence_found = presence_flag;
         r.read_data      = last_read;
         expected_ticks.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
         if (act_v !== exp_v) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         end
      endfunction

      // Compare one accepted result against the oldest expectation
      function void check_tick_result(logic [15:0] raw);
         owbm_pkg::rsp_type exp_r;
         owbm_pkg::rsp_type act_r;
         if (expected_ticks.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual %h", $time, raw);
            return;
         end
         exp_r = expected_ticks.pop_front();
         act_r = owbm_pkg::rsp_type'(raw[owbm_pkg::RSP_W-1:0]);
         compare_field("drive_low", 8'(exp_r.drive_low), 8'(act_r.drive_low));
         compare_field("busy_res", 8'(exp_r.busy_res), 8'(act_r.busy_res));
         compare_field("rejected", 8'(exp_r.rejected), 8'(act_r.rejected));
         compare_field("done_res", 8'(exp_r.done_res), 8'(act_r.done_res));
         compare_field("presence_found", 8'(exp_r.presence_found),
                       8'(act_r.presence_found));
         compare_field("read_data", exp_r.read_data, act_r.read_data);
         compare_field("padding", 8'd0, 8'(raw[15:owbm_pkg::RSP_W]));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [7:0] data_byte, [8] line_level
   logic [1:0]  req_tuser;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [0] drive_low, [1] busy_res, [2] rejected, [3] done_res,
                             // [4] presence_found, [12:5] read_data
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   one_wire_predictor bus;
   int burst_left;
   int stall_cycles;
   bit hold_armed;
   bit hold_done;

   one_wire_bus_master_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         bus.check_tick_result(rsp_tdata);
   end

   // Watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Result-side ready: random segments of stall patterns, plus one long hold-off
   initial begin : rsp_ready_gen
      int seg_left;
      int mode;
      seg_left   = 0;
      mode       = 0;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_armed && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(1, 40);
            mode     = $urandom_range(0, 3);
         end
         seg_left--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) == 1);
            2:       rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
         @(posedge clock);
      end
   end

   function automatic logic line_of(int mode);
      case (mode)
         LINE_LOW:  return 1'b0;
         LINE_HIGH: return 1'b1;
         default:   return ($urandom_range(0, 1) == 1);
      endcase
   endfunction

   // Offer one request in bursts with random gaps; returns once it is accepted
   task automatic send_request(input owbm_pkg::op_type op, input logic [7:0] data_byte,
                               input logic line_level);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, line_level, data_byte};
      do @(posedge clock); while (req_tready !== 1'b1);
      bus.advance_tick(op, data_byte, line_level);
   endtask

   // Stop offering and wait for every outstanding result
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (bus.expected_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all eight timing registers; register i sits in bits [16*i +: 16]
   task automatic load_timing(input logic [127:0] values);
      owbm_pkg::reg_index_type idx;
      for (int i = 0; i < 8; i++) begin
         idx = owbm_pkg::reg_index_type'(i);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= values[16*i +: 16];
         @(posedge clock);
         bus.set_timing(idx, values[16*i +: 16]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [127:0] random_small_timing();
      logic [127:0] values;
      for (int i = 0; i < 8; i++)
         values[16*i +: 16] = 16'($urandom_range(0, 9));
      return values;
   endfunction

   // One complete transaction, optionally with a start request while busy
   task automatic run_transaction(input owbm_pkg::op_type op, input logic [7:0] data_byte,
                                  input int line_mode, input bit intrude);
      send_request(op, data_byte, line_of(line_mode));
      if (intrude && bus.phase != owbm_pkg::OP_TICK)
         send_request(owbm_pkg::OP_WRITE, 8'hFF, line_of(line_mode));
      while (bus.phase != owbm_pkg::OP_TICK)
         send_request(owbm_pkg::OP_TICK, 8'($urandom_range(0, 255)), line_of(line_mode));
   endtask

   // Mostly well-formed transactions; a few stray starts while busy
   function automatic void pick_request(output owbm_pkg::op_type op,
                                        output logic [7:0] data_byte,
                                        output logic line_level);
      case ($urandom_range(0, 7))
         0:       data_byte = 8'h00;
         1:       data_byte = 8'hFF;
         default: data_byte = 8'($urandom_range(0, 255));
      endcase
      line_level = ($urandom_range(0, 1) == 1);
      if (bus.phase == owbm_pkg::OP_TICK)
         op = ($urandom_range(0, 9) < 2) ? owbm_pkg::OP_TICK
                                         : owbm_pkg::op_type'($urandom_range(1, 3));
      else
         op = ($urandom_range(0, 19) == 0) ? owbm_pkg::op_type'($urandom_range(1, 3))
                                           : owbm_pkg::OP_TICK;
   endfunction

   task automatic run_random(input int count);
      owbm_pkg::op_type op;
      logic [7:0]       data_byte;
      logic             line_level;
      repeat (count) begin
         pick_request(op, data_byte, line_level);
         send_request(op, data_byte, line_level);
      end
      while (bus.phase != owbm_pkg::OP_TICK)
         send_request(owbm_pkg::OP_TICK, 8'($urandom_range(0, 255)), line_of(LINE_RANDOM));
      drain();
   endtask

   // Main sequence
   initial begin
      bus          = new();
      burst_left   = 0;
      hold_armed   = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = owbm_pkg::OP_TICK;
      csr_we       = 1'b0;
      csr_index    = owbm_pkg::REG_RESET_LOW;
      csr_wdata    = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Timing registers at their reset values: opening ticks of a bus reset
      send_request(owbm_pkg::OP_RESET, 8'h00, 1'b0);
      send_request(owbm_pkg::OP_READ, 8'h00, 1'b0);
      repeat (30) send_request(owbm_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'b0);
      drain();

      // Directed: shorter periods end the running reset; one-tick slots,
      // zero low times, low time equal to the period
      load_timing({16'd1, 16'd0, 16'd0, 16'd1, 16'd0, 16'd3, 16'd1, 16'd2});
      send_request(owbm_pkg::OP_TICK, 8'h00, 1'b0);
      send_request(owbm_pkg::OP_TICK, 8'hFF, 1'b1);
      run_transaction(owbm_pkg::OP_RESET, 8'hFF, LINE_LOW, 1'b1);
      run_transaction(owbm_pkg::OP_WRITE, 8'hA5, LINE_RANDOM, 1'b0);
      run_transaction(owbm_pkg::OP_READ, 8'h00, LINE_RANDOM, 1'b0);
      drain();

      // Random requests over minimal and random small timings
      for (int k = 0; k < 5; k++) begin
         load_timing((k == 0) ? {8{16'd1}} : random_small_timing());
         if (k == 1)
            hold_armed = 1'b1;
         run_random(40);
      end

      // Extremes: full-scale low times, reset sample outside the period
      load_timing({16'd1, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd20, 16'd65535,
                   16'd65535});
      run_transaction(owbm_pkg::OP_RESET, 8'h00, LINE_RANDOM, 1'b1);
      run_transaction(owbm_pkg::OP_WRITE, 8'($urandom_range(0, 255)), LINE_RANDOM, 1'b0);
      run_transaction(owbm_pkg::OP_READ, 8'h00, LINE_HIGH, 1'b0);
      drain();

      load_timing(random_small_timing());
      run_random(40);

      repeat (8) @(posedge clock);
      if (bus.errors == 0 && bus.expected_ticks.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
